// File: rtl/srad_local_q_coefficient_unit_macros.svh
// Assertion helpers for the checker file.
`ifndef SRAD_LOCAL_Q_COEFFICIENT_UNIT_MACROS_SVH
`define SRAD_LOCAL_Q_COEFFICIENT_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define SRLQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SRLQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/srlq_pkg.sv
// ----------------------------------------------------------------------------
// srlq_pkg
// Types, constants and float32 helpers (add, multiply halves, rounding) for
// the SRAD local coefficient unit.
// ----------------------------------------------------------------------------
`default_nettype none

package srlq_pkg;

  localparam logic [31:0] F_ONE       = 32'h3F80_0000;
  localparam logic [31:0] F_HALF      = 32'h3F00_0000;
  localparam logic [31:0] F_QUARTER   = 32'h3E80_0000;
  localparam logic [31:0] F_SIXTEENTH = 32'h3D80_0000;
  localparam logic [31:0] F_ZERO      = 32'h0000_0000;
  localparam logic [31:0] F_QNAN      = 32'h7FC0_0000;
  localparam logic [30:0] F_INF_MAG   = 31'h7F80_0000;

  localparam int PADDR_W = 3;
  localparam logic REG_BYPASS_IDX = 1'b0;  // word index of bypass_math

  localparam int SIDE_W       = 33;  // {flag, float word} riding along a reciprocal
  localparam int RECIP_BITS   = 3;   // quotient bits per divider stage
  localparam int RECIP_STAGES = 9;   // 27 quotient bits

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [10:0] e0;
    logic [47:0]        p;
  } mulp_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [10:0] ea;
    logic [23:0]        m;
    logic [24:0]        r;
    logic [26:0]        q;
    logic [SIDE_W-1:0]  side;
  } recip_t;

  typedef struct packed {
    logic        vld;
    logic        cbad;
    logic [31:0] sc;
    logic [31:0] sc2;
    logic [31:0] grad;
    logic [31:0] lap;
  } front_t;

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (|a[22:0]);
  endfunction

  function automatic logic is_inf(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  // pn has its leading one at bit 47 for a normal value with biased exponent e;
  // e below 1 denormalizes, rounding is to nearest even
  function automatic logic [31:0] round_pack(input logic sign, input logic signed [10:0] e,
                                             input logic [47:0] pn, input logic sti);
    logic [10:0] shf;
    logic [47:0] q;
    logic [47:0] msk;
    logic        lost;
    logic        st;
    logic        up;
    logic [7:0]  ef;
    logic [30:0] mag;
    if (e >= 11'sd255) return {sign, F_INF_MAG};
    shf = (e < 11'sd1) ? $unsigned(11'sd1 - e) : 11'd0;
    if (shf >= 11'd48) begin
      q    = '0;
      msk  = '1;
      lost = |pn;
    end else begin
      q    = pn >> shf[5:0];
      msk  = ~(48'hFFFF_FFFF_FFFF << shf[5:0]);
      lost = |(pn & msk);
    end
    st  = (|q[22:0]) | lost | sti;
    up  = q[23] & (st | q[24]);
    ef  = (e < 11'sd1) ? 8'd0 : e[7:0];
    mag = {ef, q[46:24]} + {30'd0, up};
    return {sign, mag};
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]        x;
    logic [31:0]        y;
    logic [7:0]         exe;
    logic [7:0]         eye;
    logic [7:0]         d;
    logic [26:0]        xm;
    logic [26:0]        ym;
    logic [26:0]        ys;
    logic               st;
    logic [27:0]        s;
    logic [5:0]         nlz;
    logic signed [10:0] e;
    if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31])))
      return F_QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    exe = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    eye = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    d   = exe - eye;
    xm  = {(x[30:23] != 8'd0), x[22:0], 3'b000};
    ym  = {(y[30:23] != 8'd0), y[22:0], 3'b000};
    if (d >= 8'd27) begin
      ys = '0;
      st = |ym;
    end else begin
      ys = ym >> d[4:0];
      st = |(ym & ~(27'h7FF_FFFF << d[4:0]));
    end
    ys[0] = ys[0] | st;
    if (x[31] ^ y[31]) s = {1'b0, xm} - {1'b0, ys};
    else s = {1'b0, xm} + {1'b0, ys};
    if (s == 28'd0) return {x[31] & y[31], 31'd0};
    nlz = lzc48({s, 20'd0});
    e   = $signed({3'b000, exe}) + 11'sd1 - $signed({5'd0, nlz});
    return round_pack(x[31], e, {s, 20'd0} << nlz, 1'b0);
  endfunction

  function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
    return fp_add(a, {~b[31], b[30:0]});
  endfunction

  // first half of a multiply: specials, exponent sum and the 24x24 product
  function automatic mulp_t mul_pre(input logic [31:0] a, input logic [31:0] b);
    mulp_t      o;
    logic [7:0] eae;
    logic [7:0] ebe;
    logic       za;
    logic       zb;
    o.sign     = a[31] ^ b[31];
    za         = (a[30:0] == 31'd0);
    zb         = (b[30:0] == 31'd0);
    o.spec     = 1'b1;
    o.spec_val = F_QNAN;
    if (is_nan(a) || is_nan(b) || (is_inf(a) && zb) || (za && is_inf(b))) begin
      o.spec_val = F_QNAN;
    end else if (is_inf(a) || is_inf(b)) begin
      o.spec_val = {o.sign, F_INF_MAG};
    end else if (za || zb) begin
      o.spec_val = {o.sign, 31'd0};
    end else begin
      o.spec = 1'b0;
    end
    eae  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    ebe  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    o.e0 = $signed({3'b000, eae}) + $signed({3'b000, ebe}) - 11'sd126;
    o.p  = {24'd0, (a[30:23] != 8'd0), a[22:0]} * {24'd0, (b[30:23] != 8'd0), b[22:0]};
    return o;
  endfunction

  // second half: normalize and round
  function automatic logic [31:0] mul_post(input mulp_t m);
    logic [5:0] lz;
    if (m.spec) return m.spec_val;
    lz = lzc48(m.p);
    return round_pack(m.sign, m.e0 - $signed({5'd0, lz}), m.p << lz, 1'b0);
  endfunction

endpackage

`default_nettype wire

// File: rtl/srlq_recip.sv
// ----------------------------------------------------------------------------
// srlq_recip
// Pipelined float32 reciprocal, 1/a rounded to nearest even. Restoring
// division, three quotient bits a stage; a side word travels with each item.
// ----------------------------------------------------------------------------
`default_nettype none

module srlq_recip (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [31:0]                  in_a,
  input  logic [srlq_pkg::SIDE_W-1:0]  in_side,
  output logic                         out_vld,
  output logic [31:0]                  out_res,
  output logic [srlq_pkg::SIDE_W-1:0]  out_side
);

  localparam int N = srlq_pkg::RECIP_STAGES;

  srlq_pkg::recip_t        st [N+1];
  logic [N:0]              vld;
  srlq_pkg::recip_t        prep_c;
  logic [31:0]             post_c;
  logic [23:0]             m0;
  logic [5:0]              lz;
  logic [7:0]              e8;
  logic signed [10:0]      ef;
  logic [25:0]             qn;
  logic                    sti;

  function automatic srlq_pkg::recip_t recip_iter(input srlq_pkg::recip_t s);
    srlq_pkg::recip_t t;
    t = s;
    for (int j = 0; j < srlq_pkg::RECIP_BITS; j++) begin
      if (t.r >= {1'b0, t.m}) begin
        t.r = t.r - {1'b0, t.m};
        t.q = {t.q[25:0], 1'b1};
      end else begin
        t.q = {t.q[25:0], 1'b0};
      end
      t.r = {t.r[23:0], 1'b0};
    end
    return t;
  endfunction

  always_comb begin
    e8              = in_a[30:23];
    m0              = {(e8 != 8'd0), in_a[22:0]};
    lz              = srlq_pkg::lzc48({m0, 24'd0});
    prep_c.sign     = in_a[31];
    prep_c.spec     = 1'b1;
    prep_c.spec_val = srlq_pkg::F_QNAN;
    if (srlq_pkg::is_nan(in_a)) begin
      prep_c.spec_val = srlq_pkg::F_QNAN;
    end else if (srlq_pkg::is_inf(in_a)) begin
      prep_c.spec_val = {in_a[31], 31'd0};
    end else if (in_a[30:0] == 31'd0) begin
      prep_c.spec_val = {in_a[31], srlq_pkg::F_INF_MAG};
    end else begin
      prep_c.spec = 1'b0;
    end
    prep_c.m    = m0 << lz;
    prep_c.ea   = $signed({3'b000, (e8 == 8'd0) ? 8'd1 : e8}) - $signed({5'd0, lz});
    prep_c.r    = 25'h080_0000;  // numerator is a one followed by zeros
    prep_c.q    = '0;
    prep_c.side = in_side;
  end

  // quotient is 2^49/m: leading bit 26 only for an exact power of two
  always_comb begin
    qn  = st[N].q[26] ? st[N].q[26:1] : st[N].q[25:0];
    sti = (st[N].r != 25'd0) | (st[N].q[26] & st[N].q[0]);
    ef  = 11'sd253 - st[N].ea + $signed({10'd0, st[N].q[26]});
    if (st[N].spec) post_c = st[N].spec_val;
    else post_c = srlq_pkg::round_pack(st[N].sign, ef, {qn, 22'd0}, sti);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld     <= {vld[N-1:0], in_vld};
      out_vld <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= prep_c;
      for (int k = 1; k <= N; k++) st[k] <= recip_iter(st[k-1]);
      out_res  <= post_c;
      out_side <= st[N].side;
    end
  end

endmodule

`default_nettype wire

// File: rtl/srlq_front.sv
// ----------------------------------------------------------------------------
// srlq_front
// Neighbor differences, squares, gradient and Laplacian sums, centre square.
// Five register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module srlq_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [31:0]           center_pixel,
  input  logic [31:0]           north_pixel,
  input  logic [31:0]           south_pixel,
  input  logic [31:0]           west_pixel,
  input  logic [31:0]           east_pixel,
  output srlq_pkg::front_t      fo
);

  logic [4:1]         vld;
  logic               cbad_c;

  // stage 1
  logic [31:0]        s1_dn, s1_ds, s1_dw, s1_de, s1_sc;
  logic               s1_cbad;
  // stage 2
  srlq_pkg::mulp_t    s2_mn, s2_ms, s2_mw, s2_me, s2_mc;
  logic [31:0]        s2_ln, s2_lw, s2_sc;
  logic               s2_cbad;
  // stage 3
  logic [31:0]        s3_qn, s3_qs, s3_qw, s3_qe, s3_sc2, s3_lap, s3_sc;
  logic               s3_cbad;
  // stage 4
  logic [31:0]        s4_ga, s4_gb, s4_sc2, s4_lap, s4_sc;
  logic               s4_cbad;

  // centre <= 0, -0 included; NaN does not compare
  assign cbad_c = !srlq_pkg::is_nan(center_pixel) &&
                  (center_pixel[31] || (center_pixel[30:0] == 31'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      fo.vld <= 1'b0;
    end else if (en) begin
      vld    <= {vld[3:1], in_vld};
      fo.vld <= vld[4];
    end

    if (en) begin
      s1_dn   <= srlq_pkg::fp_sub(north_pixel, center_pixel);
      s1_ds   <= srlq_pkg::fp_sub(south_pixel, center_pixel);
      s1_dw   <= srlq_pkg::fp_sub(west_pixel, center_pixel);
      s1_de   <= srlq_pkg::fp_sub(east_pixel, center_pixel);
      s1_cbad <= cbad_c;
      s1_sc   <= cbad_c ? srlq_pkg::F_ONE : center_pixel;

      s2_mn   <= srlq_pkg::mul_pre(s1_dn, s1_dn);
      s2_ms   <= srlq_pkg::mul_pre(s1_ds, s1_ds);
      s2_mw   <= srlq_pkg::mul_pre(s1_dw, s1_dw);
      s2_me   <= srlq_pkg::mul_pre(s1_de, s1_de);
      s2_mc   <= srlq_pkg::mul_pre(s1_sc, s1_sc);
      s2_ln   <= srlq_pkg::fp_add(s1_dn, s1_ds);
      s2_lw   <= srlq_pkg::fp_add(s1_dw, s1_de);
      s2_sc   <= s1_sc;
      s2_cbad <= s1_cbad;

      s3_qn   <= srlq_pkg::mul_post(s2_mn);
      s3_qs   <= srlq_pkg::mul_post(s2_ms);
      s3_qw   <= srlq_pkg::mul_post(s2_mw);
      s3_qe   <= srlq_pkg::mul_post(s2_me);
      s3_sc2  <= srlq_pkg::mul_post(s2_mc);
      s3_lap  <= srlq_pkg::fp_add(s2_ln, s2_lw);
      s3_sc   <= s2_sc;
      s3_cbad <= s2_cbad;

      s4_ga   <= srlq_pkg::fp_add(s3_qn, s3_qs);
      s4_gb   <= srlq_pkg::fp_add(s3_qw, s3_qe);
      s4_sc2  <= s3_sc2;
      s4_lap  <= s3_lap;
      s4_sc   <= s3_sc;
      s4_cbad <= s3_cbad;

      fo.grad <= srlq_pkg::fp_add(s4_ga, s4_gb);
      fo.sc2  <= s4_sc2;
      fo.lap  <= s4_lap;
      fo.sc   <= s4_sc;
      fo.cbad <= s4_cbad;
    end
  end

endmodule

`default_nettype wire

// File: rtl/srad_local_q_coefficient_unit.sv
// ----------------------------------------------------------------------------
// srad_local_q_coefficient_unit
// SRAD squared instantaneous coefficient of variation of one pixel, float32.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  in       | sink      | in_valid / in_stall     | center/north/south/west/east_pixel
//  out      | source    | out_valid / out_stall   | q_squared, valid_flag
//  cfg      | sink      | APB psel/penable/pready | bypass_math at word 0
//
// One word per cycle while in_stall is low. A word passes 5 front stages,
// two 11-stage reciprocal pipelines in series (9 divider stages of 3
// quotient bits each) and 10 multiply/add stages.
// Reset clears valid bits, the skid register's full flag and bypass_math.
// A stalled result moves into a skid register; in_stall rises only while
// the skid register is full, and then the whole pipeline holds.
// ----------------------------------------------------------------------------
`default_nettype none

module srad_local_q_coefficient_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srlq_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   center_pixel,
  input  logic [31:0]                   north_pixel,
  input  logic [31:0]                   south_pixel,
  input  logic [31:0]                   west_pixel,
  input  logic [31:0]                   east_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   q_squared,
  output logic                          valid_flag
);

  logic                         bypass;
  logic                         en;
  srlq_pkg::front_t             fo;

  logic                         a_vld, b_vld, c_vld;
  logic [31:0]                  a_res, b_res, c_res;
  logic [srlq_pkg::SIDE_W-1:0]  a_side, b_side, c_side;

  logic [10:1]                  tv;
  srlq_pkg::mulp_t              t1_mg, t1_ml;
  logic                         t1_bad, t2_bad, t3_bad, t4_bad;
  logic                         t5_bad, t6_bad, t7_bad, t8_bad, t9_bad;
  logic [31:0]                  t2_g2, t2_l;
  srlq_pkg::mulp_t              t3_mll, t3_mql, t3_mhg;
  logic [31:0]                  t4_ll, t4_ql, t4_hg;
  srlq_pkg::mulp_t              t5_msl;
  logic [31:0]                  t5_base, t5_hg;
  logic [31:0]                  t6_sll, t6_base, t6_hg;
  logic [31:0]                  t7_num;
  srlq_pkg::mulp_t              t7_mden;
  logic [31:0]                  t8_den, t8_num;
  logic                         dbad;
  srlq_pkg::mulp_t              t9_m;
  logic [31:0]                  p_q;
  logic                         p_f;

  logic                         skid_full;
  logic [31:0]                  skid_q;
  logic                         skid_f;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == srlq_pkg::REG_BYPASS_IDX) ? {31'd0, bypass} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == srlq_pkg::REG_BYPASS_IDX)) begin
      bypass <= pwdata[0];
    end
  end

  assign en       = !skid_full;
  assign in_stall = skid_full;

  srlq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_vld       (in_valid),
    .center_pixel (center_pixel),
    .north_pixel  (north_pixel),
    .south_pixel  (south_pixel),
    .west_pixel   (west_pixel),
    .east_pixel   (east_pixel),
    .fo           (fo)
  );

  // 1/c^2 with the gradient alongside, 1/c with the Laplacian alongside
  srlq_recip u_recip_sq (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (fo.vld),
    .in_a     (fo.sc2),
    .in_side  ({fo.cbad, fo.grad}),
    .out_vld  (a_vld),
    .out_res  (a_res),
    .out_side (a_side)
  );

  srlq_recip u_recip_c (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (fo.vld),
    .in_a     (fo.sc),
    .in_side  ({fo.cbad, fo.lap}),
    .out_vld  (b_vld),
    .out_res  (b_res),
    .out_side (b_side)
  );

  assign dbad = (t8_den[30:0] == srlq_pkg::F_ZERO[30:0]);

  srlq_recip u_recip_den (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (tv[8]),
    .in_a     (dbad ? srlq_pkg::F_ONE : t8_den),
    .in_side  ({t8_bad | dbad, t8_num}),
    .out_vld  (c_vld),
    .out_res  (c_res),
    .out_side (c_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= '0;
    end else if (en) begin
      tv[1]    <= a_vld & b_vld;
      tv[8:2]  <= tv[7:1];
      tv[9]    <= c_vld;
      tv[10]   <= tv[9];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_mg   <= srlq_pkg::mul_pre(a_side[31:0], a_res);
      t1_ml   <= srlq_pkg::mul_pre(b_side[31:0], b_res);
      t1_bad  <= a_side[32] | b_side[32];

      t2_g2   <= srlq_pkg::mul_post(t1_mg);
      t2_l    <= srlq_pkg::mul_post(t1_ml);
      t2_bad  <= t1_bad;

      t3_mll  <= srlq_pkg::mul_pre(t2_l, t2_l);
      t3_mql  <= srlq_pkg::mul_pre(srlq_pkg::F_QUARTER, t2_l);
      t3_mhg  <= srlq_pkg::mul_pre(srlq_pkg::F_HALF, t2_g2);
      t3_bad  <= t2_bad;

      t4_ll   <= srlq_pkg::mul_post(t3_mll);
      t4_ql   <= srlq_pkg::mul_post(t3_mql);
      t4_hg   <= srlq_pkg::mul_post(t3_mhg);
      t4_bad  <= t3_bad;

      t5_msl  <= srlq_pkg::mul_pre(srlq_pkg::F_SIXTEENTH, t4_ll);
      t5_base <= srlq_pkg::fp_add(srlq_pkg::F_ONE, t4_ql);
      t5_hg   <= t4_hg;
      t5_bad  <= t4_bad;

      t6_sll  <= srlq_pkg::mul_post(t5_msl);
      t6_base <= t5_base;
      t6_hg   <= t5_hg;
      t6_bad  <= t5_bad;

      t7_num  <= srlq_pkg::fp_sub(t6_hg, t6_sll);
      t7_mden <= srlq_pkg::mul_pre(t6_base, t6_base);
      t7_bad  <= t6_bad;

      t8_den  <= srlq_pkg::mul_post(t7_mden);
      t8_num  <= t7_num;
      t8_bad  <= t7_bad;

      t9_m    <= srlq_pkg::mul_pre(c_side[31:0], c_res);
      t9_bad  <= c_side[32];

      p_q     <= (bypass | t9_bad) ? srlq_pkg::F_ONE : srlq_pkg::mul_post(t9_m);
      p_f     <= !(bypass | t9_bad);
    end
  end

  // output skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!out_stall) skid_full <= 1'b0;
    end else if (tv[10] && out_stall) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full && tv[10] && out_stall) begin
      skid_q <= p_q;
      skid_f <= p_f;
    end
  end

  assign out_valid  = skid_full | tv[10];
  assign q_squared  = skid_full ? skid_q : p_q;
  assign valid_flag = skid_full ? skid_f : p_f;

endmodule

`default_nettype wire

// File: rtl/srlq_checker.sv
// ----------------------------------------------------------------------------
// srlq_checker
// Port-level checks for the SRAD local coefficient unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "srad_local_q_coefficient_unit_macros.svh"

module srlq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_stall,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] q_squared,
  input  logic        valid_flag
);

  `SRLQ_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(q_squared) && $stable(valid_flag), "stalled word changed")

  `SRLQ_ASSERT_IMP(a_guard_one, out_valid && !valid_flag, q_squared == srlq_pkg::F_ONE, "guarded word is not 1.0")

  // input only backs up while a result sits in the skid register
  `SRLQ_ASSERT_IMP(a_stall_cause, in_stall, out_valid, "input stalled with no result waiting")

  `SRLQ_ASSERT_NXT(a_skid_drain, in_stall && out_valid && !out_stall, !in_stall, "skid register did not drain")

endmodule

bind srad_local_q_coefficient_unit srlq_checker u_srlq_checker (.*);

`default_nettype wire
